[rtl/tdf_pkg.sv]
// shared types and constants for the timed delay fifo
package tdf_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int TAG_BITS  = 16;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_DRAIN   = 2'd2,
        CMD_POP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_ADVANCE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_COLLECT
    } state_t;

    typedef struct packed {
        cell_op_t             op;
        logic [TIME_BITS-1:0] amount;
        logic [TAG_BITS-1:0]  tag;
    } cell_ctrl_t;

    typedef struct packed {
        cmd_t                 command;
        logic [TAG_BITS-1:0]  payload;
        logic [TIME_BITS-1:0] amount;
    } tdf_in_t;

    typedef struct packed {
        status_t              status;
        logic [TAG_BITS-1:0]  payload_out;
        logic [CNT_BITS-1:0]  removed_count;
        logic [CNT_BITS-1:0]  queue_length;
        logic [TIME_BITS-1:0] head_delay;
        logic                 is_empty;
    } tdf_out_t;

endpackage

[rtl/tdf_cell.sv]
// one queue slot: tag, countdown delay and valid flag, shifting towards the head
module tdf_cell
    import tdf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  logic                 prev_valid,
    input  logic                 nb_valid,
    input  logic [TAG_BITS-1:0]  nb_tag,
    input  logic [TIME_BITS-1:0] nb_delay,
    output logic                 valid,
    output logic [TAG_BITS-1:0]  tag,
    output logic [TIME_BITS-1:0] delay
);

    logic                 valid_reg, valid_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [TIME_BITS-1:0] delay_reg, delay_next;

    always_comb begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        delay_next = delay_reg;
        case (ctrl.op)
            CELL_LOAD: begin
                if (!valid_reg && prev_valid) begin
                    valid_next = 1'b1;
                    tag_next   = ctrl.tag;
                    delay_next = ctrl.amount;
                end
            end
            CELL_SHIFT: begin
                valid_next = nb_valid;
                tag_next   = nb_tag;
                delay_next = nb_delay;
            end
            CELL_ADVANCE: begin
                if (delay_reg >= ctrl.amount) begin
                    delay_next = delay_reg - ctrl.amount;
                end else begin
                    delay_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        tag_reg   <= tag_next;
        delay_reg <= delay_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign delay = delay_reg;

endmodule

[rtl/timed_delay_fifo_unit.sv]
// top level of the timed delay fifo: command sequencer and row of queue cells
//
// input beats on s_valid/s_ready/s_data carry a command (insert, advance,
// drain, pop), a tag and a tick amount; each beat yields exactly one result
// beat on m_valid/m_ready/m_data with status, popped tag, removed count,
// length, head delay and empty flag
// insert, advance and pop load the result register from the collect state that
// follows acceptance, once the register is free; drain first shifts the cell row
// once per expired head removed, then loads the result register the same way
// a new beat is taken only after the previous result is registered, so beats
// are worked one at a time
// all cells decrement in parallel on advance and shift together on pop/drain
// reset empties the queue and drops any pending result
// while the receiver stalls, the result register holds its beat; a following
// beat is still accepted and worked, then waits for the register to free
module timed_delay_fifo_unit
    import tdf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tdf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tdf_out_t m_data
);

    logic                 cell_valid [DEPTH];
    logic [TAG_BITS-1:0]  cell_tag   [DEPTH];
    logic [TIME_BITS-1:0] cell_delay [DEPTH];
    cell_ctrl_t           ctrl;

    state_t              state_reg, state_next;
    logic                drain_reg, drain_next;
    status_t             status_reg, status_next;
    logic [TAG_BITS-1:0] tagout_reg, tagout_next;
    logic [CNT_BITS-1:0] removed_reg, removed_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    tdf_out_t            m_data_reg, m_data_next;

    logic accept;
    logic expired;
    logic out_free;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                 pv;
            logic                 nv;
            logic [TAG_BITS-1:0]  nt;
            logic [TIME_BITS-1:0] nd;
            if (gi == 0) begin : g_first
                assign pv = 1'b1;
            end else begin : g_rest
                assign pv = cell_valid[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign nv = 1'b0;
                assign nt = '0;
                assign nd = '0;
            end else begin : g_mid
                assign nv = cell_valid[gi+1];
                assign nt = cell_tag[gi+1];
                assign nd = cell_delay[gi+1];
            end
            tdf_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_valid (pv),
                .nb_valid   (nv),
                .nb_tag     (nt),
                .nb_delay   (nd),
                .valid      (cell_valid[gi]),
                .tag        (cell_tag[gi]),
                .delay      (cell_delay[gi])
            );
        end
    endgenerate

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign expired  = cell_valid[0] && (cell_delay[0] == '0);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        drain_next   = drain_reg;
        status_next  = status_reg;
        tagout_next  = tagout_reg;
        removed_next = removed_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctrl.op      = CELL_HOLD;
        ctrl.amount  = s_data.amount;
        ctrl.tag     = s_data.payload;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_COLLECT;
                    drain_next   = 1'b0;
                    status_next  = ST_OK;
                    tagout_next  = '0;
                    removed_next = '0;
                    case (s_data.command)
                        CMD_INSERT: begin
                            if (count_reg == CNT_BITS'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.op    = CELL_LOAD;
                                count_next = count_reg + CNT_BITS'(1);
                            end
                        end
                        CMD_ADVANCE: begin
                            ctrl.op = CELL_ADVANCE;
                        end
                        CMD_DRAIN: begin
                            drain_next = 1'b1;
                        end
                        CMD_POP: begin
                            if (!cell_valid[0]) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.op      = CELL_SHIFT;
                                tagout_next  = cell_tag[0];
                                removed_next = CNT_BITS'(1);
                                count_next   = count_reg - CNT_BITS'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COLLECT: begin
                if (drain_reg && expired) begin
                    ctrl.op      = CELL_SHIFT;
                    removed_next = removed_reg + CNT_BITS'(1);
                    count_next   = count_reg - CNT_BITS'(1);
                end else if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.payload_out    = tagout_reg;
                    m_data_next.removed_count  = removed_reg;
                    m_data_next.queue_length   = count_reg;
                    m_data_next.head_delay     = cell_valid[0] ? cell_delay[0] : '1;
                    m_data_next.is_empty       = !cell_valid[0];
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        drain_reg   <= drain_next;
        status_reg  <= status_next;
        tagout_reg  <= tagout_next;
        removed_reg <= removed_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
